>>> hdl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and codes for the ordered list store: request kinds, status
// codes, datapath operation codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package ols_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 7;
    localparam int AMT_W   = 7;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 7;
    localparam int STAT_W  = 2;
    localparam int OP_W    = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELVAL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELPOS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd6;

    // result status
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // datapath operations, one per cycle
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_APPEND   = 5'd2;
    localparam logic [OP_W-1:0] OP_UPDATE   = 5'd3;
    localparam logic [OP_W-1:0] OP_READ     = 5'd4;
    localparam logic [OP_W-1:0] OP_CLEAR    = 5'd5;
    localparam logic [OP_W-1:0] OP_INS_INIT = 5'd6;
    localparam logic [OP_W-1:0] OP_INS_RD   = 5'd7;
    localparam logic [OP_W-1:0] OP_INS_WR   = 5'd8;
    localparam logic [OP_W-1:0] OP_FILL_INIT= 5'd9;
    localparam logic [OP_W-1:0] OP_FILL     = 5'd10;
    localparam logic [OP_W-1:0] OP_INS_END  = 5'd11;
    localparam logic [OP_W-1:0] OP_DV_INIT  = 5'd12;
    localparam logic [OP_W-1:0] OP_FWD_RD   = 5'd13;
    localparam logic [OP_W-1:0] OP_DV_WR    = 5'd14;
    localparam logic [OP_W-1:0] OP_DV_END   = 5'd15;
    localparam logic [OP_W-1:0] OP_DA_INIT  = 5'd16;
    localparam logic [OP_W-1:0] OP_DA_WR    = 5'd17;
    localparam logic [OP_W-1:0] OP_DA_END   = 5'd18;
    localparam logic [OP_W-1:0] OP_RESULT   = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STAT_W-1:0] status;
        logic              rd_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic len_full;
        logic pos_gt_len;
        logic pos_ge_len;
        logic amt_over;
        logic amt_zero;
        logic src_gt_pos;
        logic src_lt_len;
        logic cnt_zero;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/ols_datapath.sv
// ----------------------------------------------------------------------------
// ols_datapath
// Entry memory, length and walk pointers, request holding registers and the
// result register. Performs one operation per cycle as told by the controller.
// ----------------------------------------------------------------------------
module ols_datapath
    import ols_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [POS_W-1:0]         i_position,
    input  logic [AMT_W-1:0]         i_amount,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [LEN_W-1:0]         o_length,
    output logic [STAT_W-1:0]        o_status
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic signed [WORD_W-1:0] mem [CAPACITY];

    logic [LW-1:0]            r_len, r_src, r_dst;
    logic [POS_W-1:0]         r_pos;
    logic [AMT_W-1:0]         r_amt, r_cnt;
    logic signed [WORD_W-1:0] r_val, r_rdata;
    logic                     r_ovalid;
    logic signed [WORD_W-1:0] r_oval;
    logic [LEN_W-1:0]         r_olen;
    logic [STAT_W-1:0]        r_ostat;

    logic [CW-1:0]            pos_c, len_c, amt_c, cap_c, sum_c, src_c;
    logic [LW-1:0]            src_m1, pos_l;
    logic                     rd_en, wr_en, out_free;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    // widened operands for the range checks
    always_comb begin
        pos_c  = CW'(r_pos);
        len_c  = CW'(r_len);
        amt_c  = CW'(r_amt);
        cap_c  = CW'(CAPACITY);
        src_c  = CW'(r_src);
        sum_c  = len_c + amt_c;
        src_m1 = r_src - 1'b1;
        pos_l  = pos_c[LW-1:0];
    end

    assign out_free = !r_ovalid || !i_stall;

    // status back to the controller
    always_comb begin
        o_stat.len_full   = (len_c >= cap_c);
        o_stat.pos_gt_len = (pos_c > len_c);
        o_stat.pos_ge_len = (pos_c >= len_c);
        o_stat.amt_over   = (amt_c > (cap_c - len_c));
        o_stat.amt_zero   = (r_amt == '0);
        o_stat.src_gt_pos = (src_c > pos_c);
        o_stat.src_lt_len = (r_src < r_len);
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.out_free   = out_free;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_src[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_dst[AW-1:0];
        wr_data = r_rdata;
        case (i_cmd.op)
            OP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = r_len[AW-1:0];
                wr_data = r_val;
            end
            OP_UPDATE: begin
                wr_en   = 1'b1;
                wr_addr = pos_l[AW-1:0];
                wr_data = r_val;
            end
            OP_READ: begin
                rd_en   = 1'b1;
                rd_addr = pos_l[AW-1:0];
            end
            OP_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = src_m1[AW-1:0];
            end
            OP_INS_WR: begin
                wr_en   = 1'b1;
            end
            OP_FILL: begin
                wr_en   = 1'b1;
                wr_data = r_val;
            end
            OP_FWD_RD: begin
                rd_en   = 1'b1;
            end
            OP_DV_WR: begin
                wr_en   = (r_rdata != r_val);
            end
            OP_DA_WR: begin
                wr_en   = 1'b1;
            end
            default: begin
                rd_en   = 1'b0;
            end
        endcase
    end

    // entry store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // request holding registers and walk pointers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_pos <= i_position;
                r_amt <= i_amount;
                r_val <= i_value;
            end
            OP_INS_INIT: begin
                r_src <= r_len;
                r_dst <= sum_c[LW-1:0];
            end
            OP_INS_RD: begin
                r_src <= src_m1;
                r_dst <= r_dst - 1'b1;
            end
            OP_FILL_INIT: begin
                r_dst <= pos_l;
                r_cnt <= r_amt;
            end
            OP_FILL: begin
                r_dst <= r_dst + 1'b1;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_DV_INIT: begin
                r_src <= '0;
                r_dst <= '0;
            end
            OP_FWD_RD: begin
                r_src <= r_src + 1'b1;
            end
            OP_DV_WR: begin
                if (r_rdata != r_val) begin
                    r_dst <= r_dst + 1'b1;
                end
            end
            OP_DA_INIT: begin
                r_src <= pos_l + 1'b1;
                r_dst <= pos_l;
            end
            OP_DA_WR: begin
                r_dst <= r_dst + 1'b1;
            end
            default: begin
                r_src <= r_src;
            end
        endcase
    end

    // list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            case (i_cmd.op)
                OP_APPEND:  r_len <= r_len + 1'b1;
                OP_CLEAR:   r_len <= '0;
                OP_INS_END: r_len <= sum_c[LW-1:0];
                OP_DV_END:  r_len <= r_dst;
                OP_DA_END:  r_len <= r_len - 1'b1;
                default:    r_len <= r_len;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT) begin
            r_oval  <= i_cmd.rd_ok ? r_rdata : '0;
            r_olen  <= len_c[LEN_W-1:0];
            r_ostat <= i_cmd.status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_read_value = r_oval;
    assign o_length     = r_olen;
    assign o_status     = r_ostat;

endmodule

>>> hdl/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ols_ctrl
// Request sequencer: decodes the held request kind and steps the datapath
// through the checks, shift and compaction walks, then posts the result.
// ----------------------------------------------------------------------------
module ols_ctrl
    import ols_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_FILL    = 4'd4;
    localparam logic [3:0] S_DV_CHK  = 4'd5;
    localparam logic [3:0] S_DV_WR   = 4'd6;
    localparam logic [3:0] S_DA_CHK  = 4'd7;
    localparam logic [3:0] S_DA_WR   = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_rd_ok, n_rd_ok;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_status   = r_status;
        n_rd_ok    = r_rd_ok;
        o_cmd.op   = OP_NONE;
        o_cmd.status = r_status;
        o_cmd.rd_ok  = r_rd_ok;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_kind   = i_kind;
                    n_status = ST_DONE;
                    n_rd_ok  = 1'b0;
                    n_state  = S_DISP;
                end
            end
            // decode and range checks
            S_DISP: begin
                n_state = S_RESP;
                case (r_kind)
                    KIND_APPEND: begin
                        if (i_stat.len_full) n_status = ST_FULL;
                        else                 o_cmd.op = OP_APPEND;
                    end
                    KIND_INSERT: begin
                        if (i_stat.pos_gt_len) begin
                            n_status = ST_RANGE;
                        end else if (i_stat.amt_over) begin
                            n_status = ST_FULL;
                        end else if (!i_stat.amt_zero) begin
                            o_cmd.op = OP_INS_INIT;
                            n_state  = S_INS_CHK;
                        end
                    end
                    KIND_UPDATE: begin
                        if (i_stat.pos_ge_len) n_status = ST_RANGE;
                        else                   o_cmd.op = OP_UPDATE;
                    end
                    KIND_DELVAL: begin
                        o_cmd.op = OP_DV_INIT;
                        n_state  = S_DV_CHK;
                    end
                    KIND_DELPOS: begin
                        if (i_stat.pos_ge_len) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_cmd.op = OP_DA_INIT;
                            n_state  = S_DA_CHK;
                        end
                    end
                    KIND_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                    end
                    KIND_READ: begin
                        if (i_stat.pos_ge_len) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_cmd.op = OP_READ;
                            n_rd_ok  = 1'b1;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            // shift the tail up, top entry first
            S_INS_CHK: begin
                if (i_stat.src_gt_pos) begin
                    o_cmd.op = OP_INS_RD;
                    n_state  = S_INS_WR;
                end else begin
                    o_cmd.op = OP_FILL_INIT;
                    n_state  = S_FILL;
                end
            end
            S_INS_WR: begin
                o_cmd.op = OP_INS_WR;
                n_state  = S_INS_CHK;
            end
            // write the run of copies
            S_FILL: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.op = OP_INS_END;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_FILL;
                end
            end
            // compaction walk, dropping matches
            S_DV_CHK: begin
                if (i_stat.src_lt_len) begin
                    o_cmd.op = OP_FWD_RD;
                    n_state  = S_DV_WR;
                end else begin
                    o_cmd.op = OP_DV_END;
                    n_state  = S_RESP;
                end
            end
            S_DV_WR: begin
                o_cmd.op = OP_DV_WR;
                n_state  = S_DV_CHK;
            end
            // shift the tail down by one
            S_DA_CHK: begin
                if (i_stat.src_lt_len) begin
                    o_cmd.op = OP_FWD_RD;
                    n_state  = S_DA_WR;
                end else begin
                    o_cmd.op = OP_DA_END;
                    n_state  = S_RESP;
                end
            end
            S_DA_WR: begin
                o_cmd.op = OP_DA_WR;
                n_state  = S_DA_CHK;
            end
            // post result once the output register is free
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

>>> hdl/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered list of signed 32-bit words in a fixed store, with append, insert
// run, update, delete by value, delete at position, clear and read requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_kind i_position i_amount i_value
//  result    out        o_valid / i_stall   o_read_value o_length o_status
//
//  One request at a time. Insert shifts the tail up, then writes the run of copies;
//  delete by value and delete at position walk the entries. The walks are bounded by
//  the single port entry memory (one read or write per cycle, registered read).
//  Reset clears the length and the result valid flag; entries need no clearing.
//  A stalled result holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module ordered_list_store
    import ols_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [POS_W-1:0]         i_position,
    input  logic [AMT_W-1:0]         i_amount,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [LEN_W-1:0]         o_length,
    output logic [STAT_W-1:0]        o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ols_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ols_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_position   (i_position),
        .i_amount     (i_amount),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_length     (o_length),
        .o_status     (o_status)
    );

endmodule

>>> sim/tb_ordered_list_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_store
// Self-checking bench for the ordered list store. A behavioral list model
// predicts every result. Directed tests cover each request kind and the
// boundary cases, then random traffic with random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_ordered_list_store;
    import ols_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [WORD_W-1:0] rd_value;
        logic [LEN_W-1:0]         len;
        logic [STAT_W-1:0]        status;
    } t_result;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [KIND_W-1:0]        req_kind;
    logic [POS_W-1:0]         req_pos;
    logic [AMT_W-1:0]         req_amt;
    logic signed [WORD_W-1:0] req_value;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [WORD_W-1:0] res_rd_value;
    logic [LEN_W-1:0]         res_len;
    logic [STAT_W-1:0]        res_status;

    // list model state
    logic [WORD_W-1:0] list_mem [CAP];
    int                list_len;
    t_result           pending_results [$];
    int                err_cnt;
    int                cycle_cnt;
    bit                calm;

    ordered_list_store i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_kind       (req_kind),
        .i_position   (req_pos),
        .i_amount     (req_amt),
        .i_value      (req_value),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_read_value (res_rd_value),
        .o_length     (res_len),
        .o_status     (res_status)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predict one request and update the list model
    function automatic t_result list_apply(logic [KIND_W-1:0] kind, int pos, int amt,
                                           logic [WORD_W-1:0] word);
        t_result r;
        int      wr;
        r = '0;
        r.status = ST_DONE;
        case (kind)
            KIND_APPEND: begin
                if (list_len >= CAP) r.status = ST_FULL;
                else begin
                    list_mem[list_len] = word;
                    list_len++;
                end
            end
            KIND_INSERT: begin
                if (pos > list_len) r.status = ST_RANGE;
                else if (amt > CAP - list_len) r.status = ST_FULL;
                else begin
                    for (int i = list_len; i > pos; i--) list_mem[i-1+amt] = list_mem[i-1];
                    for (int i = 0; i < amt; i++) list_mem[pos+i] = word;
                    list_len += amt;
                end
            end
            KIND_UPDATE: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else list_mem[pos] = word;
            end
            KIND_DELVAL: begin
                wr = 0;
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] != word) begin
                        list_mem[wr] = list_mem[i];
                        wr++;
                    end
                list_len = wr;
            end
            KIND_DELPOS: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else begin
                    for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            KIND_CLEAR: list_len = 0;
            KIND_READ: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else r.rd_value = list_mem[pos];
            end
            default: ;
        endcase
        r.len = list_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        $display("MISMATCH %s: got %0d expected %0d", what, got, exp_v);
        err_cnt++;
    endtask

    // send one request transaction, with random idle before it;
    // valid stays up across back-to-back transactions
    task automatic send_req(logic [KIND_W-1:0] kind, int pos, int amt, logic [WORD_W-1:0] word);
        while (!calm && $urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_pos   <= pos[POS_W-1:0];
        req_amt   <= amt[AMT_W-1:0];
        req_value <= word;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pending_results.push_back(list_apply(kind, pos, amt, word));
        @(negedge clk);
    endtask

    // result stall generator
    always @(negedge clk) begin
        if (!rst_n) res_stall <= 1'b0;
        else res_stall <= !calm && ($urandom_range(99) < 12);
    end

    // result checker
    always @(posedge clk) begin
        t_result e;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (res_rd_value !== e.rd_value) report_mismatch("read_value", res_rd_value, e.rd_value);
                if (res_len !== e.len) report_mismatch("length", res_len, e.len);
                if (res_status !== e.status) report_mismatch("status", res_status, e.status);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_basic_kinds();
        send_req(KIND_READ, 0, 1, 0);
        send_req(KIND_DELPOS, 0, 1, 0);
        send_req(KIND_UPDATE, 0, 1, 5);
        send_req(KIND_APPEND, 0, 1, 32'h8000_0000);
        send_req(KIND_APPEND, 0, 1, 32'h7FFF_FFFF);
        send_req(KIND_APPEND, 0, 1, 32'hFFFF_FFFF);
        send_req(KIND_UPDATE, 1, 1, 32'h1234_5678);
        send_req(KIND_READ, 1, 1, 0);
        send_req(KIND_READ, 3, 1, 0);
        send_req(KIND_READ, 127, 1, 0);
        send_req(KIND_INSERT, 1, 0, 9);
        send_req(KIND_INSERT, 5, 1, 9);
        send_req(KIND_INSERT, 1, 3, 9);
        send_req(KIND_READ, 2, 1, 0);
        send_req(KIND_DELVAL, 0, 1, 9);
        send_req(KIND_DELVAL, 0, 1, 77);
        send_req(KIND_DELPOS, 0, 1, 0);
        send_req(KIND_UNUSED, 127, 127, 32'hFFFF_FFFF);
        send_req(KIND_CLEAR, 0, 1, 0);
    endtask

    task automatic test_capacity();
        send_req(KIND_INSERT, 0, 64, 32'hA5A5_A5A5);
        send_req(KIND_APPEND, 0, 1, 1);
        send_req(KIND_INSERT, 64, 1, 1);
        send_req(KIND_INSERT, 65, 1, 1);
        send_req(KIND_READ, 63, 1, 0);
        send_req(KIND_DELVAL, 0, 1, 32'hA5A5_A5A5);
        send_req(KIND_INSERT, 0, 127, 1);
    endtask

    task automatic test_random(int n);
        int k, pos, amt, cnt;
        logic [KIND_W-1:0] kind;
        cnt = 0;
        while (cnt < n) begin
            calm = (cnt >= n / 2 && cnt < n / 2 + 200);
            k = $urandom_range(99);
            if (k < 25) kind = KIND_APPEND;
            else if (k < 40) kind = KIND_INSERT;
            else if (k < 50) kind = KIND_UPDATE;
            else if (k < 58) kind = KIND_DELVAL;
            else if (k < 70) kind = KIND_DELPOS;
            else if (k < 72) kind = KIND_CLEAR;
            else if (k < 97) kind = KIND_READ;
            else kind = KIND_UNUSED;
            // positions mostly in range, sometimes anywhere in the field
            if ($urandom_range(9) == 0) pos = $urandom_range(127);
            else pos = $urandom_range(list_len);
            if ($urandom_range(19) == 0) amt = $urandom_range(127);
            else amt = $urandom_range(1, 8);
            send_req(kind, pos, amt, (kind == KIND_DELVAL && list_len > 0 &&
                     $urandom_range(1)) ? list_mem[$urandom_range(list_len - 1)] : rand_word());
            cnt++;
        end
        calm = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_kind  = '0;
        req_pos   = '0;
        req_amt   = '0;
        req_value = '0;
        res_stall = 1'b0;
        err_cnt   = 0;
        cycle_cnt = 0;
        calm      = 1'b0;
        list_len  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_basic_kinds();
        test_capacity();
        test_random(2000);
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
